@@ rtl/core/vgdr_pkg.sv @@
package vgdr_pkg;

  localparam int unsigned SEQ_W     = 32;
  localparam int unsigned REWIND_W  = 4;
  // Widest slot index for the largest supported ring (256 slots)
  localparam int unsigned SLOT_BITS = 8;

  localparam logic [REWIND_W-1:0] REWIND_RESET = 4'd2;
  localparam logic [REWIND_W-1:0] REWIND_MIN   = 4'd1;
  localparam logic [REWIND_W-1:0] REWIND_MAX   = 4'd14;

  typedef enum logic [1:0] {
    ACT_ENCODE  = 2'd0,
    ACT_FORWARD = 2'd1,
    ACT_SKIP    = 2'd2
  } action_e;

  // One classified frame, front to back
  typedef struct packed {
    logic [SEQ_W-1:0]     newest_seq;
    logic [SLOT_BITS-1:0] newest_slot;
    logic [SEQ_W-1:0]     start_seq;
    logic [SLOT_BITS-1:0] start_slot;
    logic [REWIND_W-1:0]  lb_count;
    action_e              lb_action;
    action_e              new_action;
  } cmd_t;

endpackage

@@ rtl/core/vgdr_front.sv @@
module vgdr_front import vgdr_pkg::*; #(
  parameter int unsigned RING_SLOTS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [REWIND_W-1:0] rewind_frames_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                voice_active_i,
  output logic                cmd_valid_o,
  input  logic                cmd_ready_i,
  output cmd_t                cmd_o
);

  localparam int unsigned SLOT_W = $clog2(RING_SLOTS);
  localparam int unsigned DW = ((SLOT_W > REWIND_W) ? SLOT_W : REWIND_W) + 2;
  localparam logic [DW-1:0]     SLOTS_D   = DW'(RING_SLOTS);
  // one past the slot of the last sequence before the wrap, i.e. where 2^32 lands mod ring size
  localparam logic [DW-1:0]     WRAP_SLOT = DW'((64'd1 << 32) % RING_SLOTS);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(RING_SLOTS - 1);

  logic [REWIND_W-1:0] rw_q;
  logic                silence_q, silence_d;
  logic [SLOT_W-1:0]   fill_q, fill_d;
  logic [SEQ_W-1:0]    seq_q;
  logic [SLOT_W-1:0]   slot_q, slot_d;

  logic                accept;
  logic [REWIND_W-1:0] rw_eff;
  logic [DW-1:0]       fill_x, rw_x, cnt_x, dist_x, diff_x;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = cmd_ready_i;
  assign cmd_valid_o = in_valid_i;
  assign accept      = in_valid_i && cmd_ready_i;

  always_comb begin
    if (rw_q < REWIND_MIN) begin
      rw_eff = REWIND_MIN;
    end else if (rw_q > REWIND_MAX) begin
      rw_eff = REWIND_MAX;
    end else begin
      rw_eff = rw_q;
    end

    if (fill_q == '0) begin
      fill_d = SLOT_W'(1);
    end else if (fill_q >= LAST_SLOT) begin
      fill_d = fill_q;
    end else begin
      fill_d = fill_q + SLOT_W'(1);
    end

    fill_x    = DW'(fill_d);
    rw_x      = DW'(rw_eff);
    cnt_x     = '0;
    dist_x    = '0;
    silence_d = silence_q;
    cmd_o.lb_action  = ACT_ENCODE;
    cmd_o.new_action = ACT_ENCODE;

    if (voice_active_i) begin
      if (silence_q) begin
        silence_d = 1'b0;
        cnt_x     = (rw_x < fill_x - DW'(1)) ? rw_x : fill_x - DW'(1);
        dist_x    = cnt_x;
      end
    end else if (!silence_q) begin
      silence_d = 1'b1;
    end else begin
      cnt_x            = (rw_x < fill_x) ? DW'(1) : '0;
      dist_x           = rw_x;
      cmd_o.lb_action  = ACT_FORWARD;
      cmd_o.new_action = ACT_SKIP;
    end

    // slot of newest - dist, minding the jump at the sequence wrap
    if (seq_q >= SEQ_W'(dist_x)) begin
      diff_x = DW'(slot_q) - dist_x;
    end else begin
      diff_x = WRAP_SLOT - (dist_x - DW'(seq_q[REWIND_W-1:0]));
    end
    if (diff_x[DW-1]) begin
      diff_x = diff_x + SLOTS_D;
    end

    if (seq_q == '1) begin
      slot_d = '0;
    end else if (slot_q == LAST_SLOT) begin
      slot_d = '0;
    end else begin
      slot_d = slot_q + SLOT_W'(1);
    end

    cmd_o.newest_seq  = seq_q;
    cmd_o.newest_slot = SLOT_BITS'(slot_q);
    cmd_o.start_seq   = seq_q - SEQ_W'(dist_x);
    cmd_o.start_slot  = SLOT_BITS'(diff_x[SLOT_W-1:0]);
    cmd_o.lb_count    = REWIND_W'(cnt_x);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rw_q      <= REWIND_RESET;
      silence_q <= 1'b0;
      fill_q    <= '0;
      seq_q     <= '0;
      slot_q    <= '0;
    end else begin
      if (cfg_valid_i) begin
        rw_q <= rewind_frames_i;
      end
      if (accept) begin
        silence_q <= silence_d;
        fill_q    <= fill_d;
        seq_q     <= seq_q + SEQ_W'(1);
        slot_q    <= slot_d;
      end
    end
  end

endmodule

@@ rtl/core/vgdr_cmd_fifo.sv @@
module vgdr_cmd_fifo import vgdr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  cmd_t push_data_i,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output cmd_t pop_data_o
);

  cmd_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       push, pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (push && !pop) begin
        count_q <= count_q + 2'd1;
      end else if (pop && !push) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

endmodule

@@ rtl/core/vgdr_back.sv @@
module vgdr_back import vgdr_pkg::*; #(
  parameter int unsigned RING_SLOTS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cmd_valid_i,
  output logic             cmd_ready_o,
  input  cmd_t             cmd_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [SEQ_W-1:0] frame_seq_o,
  output logic [1:0]       action_o,
  output logic             last_o
);

  localparam int unsigned SLOT_W = $clog2(RING_SLOTS);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(RING_SLOTS - 1);

  logic [RING_SLOTS-1:0] marks_q, marks_d;
  logic                  busy_q, busy_d;
  logic [REWIND_W-1:0]   cnt_q, cnt_d;
  logic [SEQ_W-1:0]      seq_q, seq_d;
  logic [SLOT_W-1:0]     slot_q, slot_d;
  cmd_t                  cmd_q;

  logic                  out_valid_q, out_valid_d;
  logic [SEQ_W-1:0]      out_seq_q, out_seq_d;
  action_e               out_act_q, out_act_d;
  logic                  out_last_q, out_last_d;

  logic                  load, adv;
  logic [SLOT_W-1:0]     new_slot, load_slot;

  assign cmd_ready_o = !busy_q;
  assign load        = cmd_valid_i && !busy_q;
  assign adv         = busy_q && (!out_valid_q || out_ready_i);
  assign new_slot    = cmd_q.newest_slot[SLOT_W-1:0];
  assign load_slot   = cmd_i.newest_slot[SLOT_W-1:0];

  assign out_valid_o = out_valid_q;
  assign frame_seq_o = out_seq_q;
  assign action_o    = out_act_q;
  assign last_o      = out_last_q;

  always_comb begin
    marks_d     = marks_q;
    busy_d      = busy_q;
    cnt_d       = cnt_q;
    seq_d       = seq_q;
    slot_d      = slot_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_seq_d   = out_seq_q;
    out_act_d   = out_act_q;
    out_last_d  = out_last_q;

    if (load) begin
      // new frame enters the ring unprocessed
      marks_d[load_slot] = 1'b0;
      busy_d = 1'b1;
      cnt_d  = cmd_i.lb_count;
      seq_d  = cmd_i.start_seq;
      slot_d = cmd_i.start_slot[SLOT_W-1:0];
    end

    if (adv) begin
      if (cnt_q != '0) begin
        if (!marks_q[slot_q]) begin
          marks_d[slot_q] = 1'b1;
          out_valid_d = 1'b1;
          out_seq_d   = seq_q;
          out_act_d   = cmd_q.lb_action;
          out_last_d  = 1'b0;
        end
        cnt_d = cnt_q - REWIND_W'(1);
        seq_d = seq_q + SEQ_W'(1);
        if (seq_q == '1 || slot_q == LAST_SLOT) begin
          slot_d = '0;
        end else begin
          slot_d = slot_q + SLOT_W'(1);
        end
      end else begin
        if (cmd_q.new_action == ACT_ENCODE) begin
          marks_d[new_slot] = 1'b1;
        end
        out_valid_d = 1'b1;
        out_seq_d   = cmd_q.newest_seq;
        out_act_d   = cmd_q.new_action;
        out_last_d  = 1'b1;
        busy_d      = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cmd_q <= cmd_i;
    end
    cnt_q     <= cnt_d;
    seq_q     <= seq_d;
    slot_q    <= slot_d;
    out_seq_q <= out_seq_d;
    out_act_q <= out_act_d;
    out_last_q <= out_last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      marks_q     <= '0;
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      marks_q     <= marks_d;
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

@@ rtl/core/vad_gated_dtx_frame_release.sv @@
// Channel   Direction  Handshake               Carries
// cfg       in         cfg_valid_i/cfg_ready_o rewind_frames_i (lookback depth)
// in        in         in_valid_i/in_ready_o   voice_active_i, one request per frame
// out       out        out_valid_o/out_ready_i frame_seq_o, action_o, last_o
//
// Back sequencer: per frame it walks the lookback steps, one ring slot per step, then
//   emits the new frame; steps are min(rewind, held - 1) on speech after silence,
//   1 or 0 on a skipped frame, 0 otherwise.
// The front takes a new frame each cycle while the 2-entry command queue has room.
// Reset clears all processed marks, the sequence count and silence mode at once.
// A stalled output holds its result; the back waits, the front fills the queue.
module vad_gated_dtx_frame_release import vgdr_pkg::*; #(
  parameter int unsigned RING_SLOTS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [REWIND_W-1:0] rewind_frames_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                voice_active_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [SEQ_W-1:0]    frame_seq_o,
  output logic [1:0]          action_o,
  output logic                last_o
);

  // front -> queue
  logic fq_valid, fq_ready;
  cmd_t fq_cmd;
  // queue -> back
  logic qb_valid, qb_ready;
  cmd_t qb_cmd;

  // Front: ring bookkeeping (fill level, next sequence and its slot),
  // silence mode, and classification of each frame into a command.
  vgdr_front #(
    .RING_SLOTS (RING_SLOTS)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .rewind_frames_i (rewind_frames_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .voice_active_i  (voice_active_i),
    .cmd_valid_o     (fq_valid),
    .cmd_ready_i     (fq_ready),
    .cmd_o           (fq_cmd)
  );

  vgdr_cmd_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fq_valid),
    .push_ready_o (fq_ready),
    .push_data_i  (fq_cmd),
    .pop_valid_o  (qb_valid),
    .pop_ready_i  (qb_ready),
    .pop_data_o   (qb_cmd)
  );

  // Back: owns the processed marks, walks the lookback window oldest first
  // and drives the registered result.
  vgdr_back #(
    .RING_SLOTS (RING_SLOTS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (qb_valid),
    .cmd_ready_o (qb_ready),
    .cmd_i       (qb_cmd),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .frame_seq_o (frame_seq_o),
    .action_o    (action_o),
    .last_o      (last_o)
  );

endmodule

@@ rtl/core/vgdr_checker.sv @@
module vgdr_checker import vgdr_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                cfg_valid_i,
  input logic                cfg_ready_o,
  input logic [REWIND_W-1:0] rewind_frames_i,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic                voice_active_i,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input logic [SEQ_W-1:0]    frame_seq_o,
  input logic [1:0]          action_o,
  input logic                last_o
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(frame_seq_o)
      && $stable(action_o) && $stable(last_o))
    else $error("stalled result changed");

  // a skipped frame always closes its request
  a_skip_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && action_o == ACT_SKIP |-> last_o)
    else $error("skip without last");

  // a forwarded frame is never the final result
  a_fwd_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && action_o == ACT_FORWARD |-> !last_o)
    else $error("forward marked last");

  // forward is followed directly by the skip of the new frame
  a_fwd_then_skip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && action_o == ACT_FORWARD
      |=> out_valid_o && action_o == ACT_SKIP)
    else $error("forward not followed by skip");

endmodule

bind vad_gated_dtx_frame_release vgdr_checker u_checker (.*);
